// ----- rtl/core/tpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg: shared types and constants
// Item structs, sequencer states and fixed-point helpers for the integrator.
// ----------------------------------------------------------------------------
package tpi_pkg;

  localparam int MAX_DEGREE_DEF    = 10;
  localparam int MAX_DIVISIONS_DEF = 65535;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_INTEGRATE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] lower_end;
    logic signed [31:0] upper_end;
    logic [15:0]        divisions;
  } tpi_in_t;

  typedef struct packed {
    logic signed [31:0] integral;
    logic signed [31:0] step_width;
    logic               overflow;
  } tpi_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_HSAT,
    ST_POINT,
    ST_HRD,
    ST_HMUL,
    ST_HADD,
    ST_ACCUM,
    ST_SC_MUL,
    ST_SC_FIN,
    ST_OUT
  } tpi_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic ov);
    logic signed [31:0] r;
    ov = 1'b0;
    r  = v[31:0];
    if (v > 66'sh0_7FFF_FFFF) begin
      ov = 1'b1;
      r  = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      ov = 1'b1;
      r  = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/trapezoid_polynomial_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_polynomial_integrator: composite trapezoid rule on a polynomial
// Coefficients live in a small RAM; one sequencer evaluates by Horner's rule.
// ----------------------------------------------------------------------------
// Usage: a load item (operation 0) writes one Q16.16 coefficient into the
// coefficient RAM and returns nothing. An integrate item (operation 1)
// returns one item with the trapezoid estimate, the step width h and an
// overflow flag. The user must see that the cfg channel writes poly_degree
// only while the block is idle; the block itself does not enforce this.
// An integrate item runs the serial division of b-a by n (a start step and
// 33 quotient bits), then evaluates the n+1 points one after another, each
// by Horner's rule, and ends with the final scaling and the hand-off
// to the output register. The Horner loop is bound by the RAM read, the
// registered multiply and the add of each step, one coefficient at a time.
// One item is worked at a time; in_stall is high while an item is in work.
// After reset, poly_degree is zero. The coefficient RAM carries a valid bit
// per entry, cleared at reset, so unwritten coefficients read as zero.
// A finished result waits in the output register while out_stall is high;
// the next item may be accepted meanwhile, and its scaling step waits until
// the output register is free.
// ----------------------------------------------------------------------------
module trapezoid_polynomial_integrator
  import tpi_pkg::*;
#(
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF,
  parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tpi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tpi_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [3:0] cfg_data
);
  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_DIVISIONS + 1);

  tpi_state_t state_r, state_nxt;

  logic [3:0]         deg_cfg_r;
  logic [DEPTH-1:0]   vld_r, vld_nxt;
  logic [NW-1:0]      n_r, n_nxt, i_r, i_nxt;
  logic [AW-1:0]      k_r, k_nxt, deg;
  logic signed [31:0] a_r, a_nxt, b_r, b_nxt, h_r, h_nxt, x_r, x_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic signed [33:0] diff_r, diff_nxt;
  logic [63:0]        sc_a_r, sc_a_nxt, sc_b_r, sc_b_nxt;
  logic               neg_r, neg_nxt, ov_r, ov_nxt, first_r, first_nxt;
  tpi_out_t           res_r, res_nxt;
  logic               ovld_r, ovld_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;
  logic               rd_vld_r;
  logic signed [31:0] coef;

  logic               div_start, div_done;
  logic [32:0]        div_q;
  logic [NW-1:0]      div_den;

  logic               in_acc;
  logic               s_ov;
  logic signed [31:0] s_val;
  logic signed [65:0] wide;
  logic [63:0]        ms;
  logic [31:0]        mh;
  logic [31:0]        lim;
  logic [63:0]        q;

  // Inner point a + i*h in full width, saturated in the point state.
  logic signed [63:0] pt_wide;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovld_r;
  assign out_data  = res_r;

  assign deg = ({1'b0, deg_cfg_r} > 5'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : AW'(deg_cfg_r);

  assign ram_we    = in_acc && (in_data.operation == OP_LOAD) &&
                     ({1'b0, in_data.coef_index} <= 5'(MAX_DEGREE));
  assign ram_waddr = AW'(in_data.coef_index);
  assign coef      = rd_vld_r ? $signed(ram_rdata) : 32'sd0;

  assign pt_wide = 64'(a_r) + 64'($signed({1'b0, i_r})) * 64'(h_r);

  tpi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.coef_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign div_den = n_r;
  tpi_div #(.DW(NW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(diff_r[33] ? 33'(-diff_r) : 33'(diff_r)),
    .divisor (div_den),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    vld_nxt   = vld_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    h_nxt     = h_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    diff_nxt  = diff_r;
    sc_a_nxt  = sc_a_r;
    sc_b_nxt  = sc_b_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r;
    first_nxt = first_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r;
    div_start = 1'b0;
    ram_raddr = k_r;
    s_ov      = 1'b0;
    s_val     = '0;
    wide      = '0;
    ms        = '0;
    mh        = '0;
    lim       = '0;
    q         = '0;
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.operation == OP_INTEGRATE) begin
          a_nxt    = in_data.lower_end;
          b_nxt    = in_data.upper_end;
          diff_nxt = 34'(in_data.upper_end) - 34'(in_data.lower_end);
          if (in_data.divisions == 16'd0) begin
            n_nxt = NW'(1);
          end else if ({4'd0, in_data.divisions} > 20'(MAX_DIVISIONS)) begin
            n_nxt = NW'(MAX_DIVISIONS);
          end else begin
            n_nxt = NW'(in_data.divisions);
          end
          ov_nxt    = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_HSAT;
      end
      ST_HSAT: begin
        if (div_done) begin
          wide  = diff_r[33] ? -66'(div_q) : 66'(div_q);
          s_val = sat32(wide, s_ov);
          h_nxt = s_val;
          ov_nxt = ov_r | s_ov;
          i_nxt = '0;
          sum_nxt = '0;
          first_nxt = 1'b1;
          state_nxt = ST_POINT;
        end
      end
      ST_POINT: begin
        // Point order: a first, then b, then the inner points.
        if (first_r) begin
          x_nxt = a_r;
        end else if (i_r == '0) begin
          x_nxt = b_r;
        end else begin
          s_val  = sat32(66'(pt_wide), s_ov);
          x_nxt  = s_val;
          ov_nxt = ov_r | s_ov;
        end
        k_nxt     = deg;
        ram_raddr = deg;
        state_nxt = ST_HRD;
      end
      ST_HRD: begin
        // Read data is the coefficient at k_r; first pass seeds acc.
        acc_nxt = coef;
        if (k_r == '0) begin
          state_nxt = ST_ACCUM;
        end else begin
          state_nxt = ST_HMUL;
        end
      end
      ST_HMUL: begin
        prod_nxt  = acc_r * x_r;
        k_nxt     = k_r - AW'(1);
        ram_raddr = k_r - AW'(1);
        state_nxt = ST_HADD;
      end
      ST_HADD: begin
        wide    = 66'((prod_r + 64'sd32768) >>> 16) + 66'(coef);
        s_val   = sat32(wide, s_ov);
        acc_nxt = s_val;
        ov_nxt  = ov_r | s_ov;
        state_nxt = (k_r == '0) ? ST_ACCUM : ST_HMUL;
      end
      ST_ACCUM: begin
        if (first_r || i_r == '0) begin
          sum_nxt = sum_r + 64'(acc_r);
        end else begin
          sum_nxt = sum_r + (64'(acc_r) <<< 1);
        end
        first_nxt = 1'b0;
        if (first_r) begin
          state_nxt = ST_POINT;
        end else begin
          i_nxt = i_r + NW'(1);
          state_nxt = ((i_r + NW'(1)) >= n_r) ? ST_SC_MUL : ST_POINT;
          // Inner point positions need a saturated a + i*h.
        end
      end
      ST_SC_MUL: begin
        ms = sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
        mh = h_r[31] ? 32'(-h_r) : 32'(h_r);
        sc_a_nxt = 64'(ms[63:32]) * 64'(mh);
        sc_b_nxt = 64'(ms[31:0]) * 64'(mh);
        neg_nxt  = sum_r[63] != h_r[31];
        state_nxt = ST_SC_FIN;
      end
      ST_SC_FIN: begin
        // The output register is only overwritten once its item has left.
        if (!ovld_r || !out_stall) begin
          lim = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          if (sc_a_r >= 64'h2_0000) begin
            q = 64'(lim) + 64'd1;
          end else begin
            q = (sc_a_r << 15) + ((sc_b_r + 64'd65536) >> 17);
          end
          if (q > 64'(lim)) begin
            ov_nxt = 1'b1;
            q = 64'(lim);
          end
          res_nxt.integral   = neg_r ? -q[31:0] : q[31:0];
          res_nxt.step_width = h_r;
          res_nxt.overflow   = ov_nxt;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ovld_r && !out_stall && state_r != ST_OUT) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      deg_cfg_r <= '0;
      vld_r     <= '0;
      ovld_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vld_r    <= vld_nxt;
      ovld_r   <= ovld_nxt;
      rd_vld_r <= vld_r[ram_raddr];
      if (cfg_valid && cfg_ready) begin
        deg_cfg_r <= cfg_data;
      end
    end
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    h_r     <= h_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    diff_r  <= diff_nxt;
    sc_a_r  <= sc_a_nxt;
    sc_b_r  <= sc_b_nxt;
    neg_r   <= neg_nxt;
    ov_r    <= ov_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("result changed");
  a_div_in_hsat: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_HSAT)) else $error("stray divide done");
endmodule

// ----- rtl/core/tpi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/tpi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_div: restoring divider
// Divides a 33-bit magnitude by a divisor one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpi_div
  import tpi_pkg::*;
#(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [32:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [32:0]   quotient
);
  logic [32:0]   q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[32]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign quotient = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule

// ----- bench/tb_trapezoid_polynomial_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trapezoid_polynomial_integrator: self-checking bench for the integrator
// Loads coefficients, sweeps the polynomial degree and checks every trapezoid
// estimate against a cycle-free predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_trapezoid_polynomial_integrator;
  import tpi_pkg::*;

  localparam int TOP_DEGREE   = 10;
  localparam int TOP_DIVS     = 65535;
  localparam int STALL_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 2000;
  localparam int SETTLE_TICKS = 60;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  tpi_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  tpi_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  trapezoid_polynomial_integrator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the block state: coefficient store and degree register.
  logic signed [31:0] coef_shadow [0:TOP_DEGREE];
  logic [3:0]         degree_shadow;

  // Estimates still owed by the block, oldest first.
  tpi_out_t estimate_q[$];

  int fail_count = 0;
  int items_sent;
  int loads_sent;
  int estimates_seen = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_ticks = 0;
  int hold_reqs;
  int holds_done = 0;
  int quiet_ticks = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate to 32 bits and note when it clips.
  function automatic logic signed [31:0] clip32(input longint v, inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Horner's rule in Q16.16; each product is rounded half up before the add.
  function automatic logic signed [31:0] horner_at(input logic signed [31:0] x,
                                                   input int deg, inout bit ov);
    logic signed [31:0] acc;
    longint prod;
    acc = coef_shadow[deg];
    for (int k = deg; k > 0; k--) begin
      prod = longint'(acc) * longint'(x);
      acc  = clip32(((prod + 32768) >>> 16) + longint'(coef_shadow[k-1]), ov);
    end
    return acc;
  endfunction

  // integral = sum*h / 2^17, rounded half away from zero, done in magnitudes.
  function automatic logic signed [31:0] scale_sum(input longint total,
                                                   input logic signed [31:0] h,
                                                   inout bit ov);
    logic [63:0] mag_s, mag_h, hi_part, lo_part, prod_hi, prod_lo, q, lim;
    bit neg;
    mag_s   = (total < 0) ? 64'(-total) : 64'(total);
    mag_h   = (h < 0) ? 64'(-longint'(h)) : 64'(longint'(h));
    hi_part = mag_s >> 32;
    lo_part = mag_s & 64'hFFFF_FFFF;
    prod_hi = hi_part * mag_h;
    prod_lo = lo_part * mag_h;
    neg     = (total < 0) != (h < 0);
    lim     = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (prod_hi >= (64'd1 << 17)) q = lim + 1;
    else q = (prod_hi << 15) + ((prod_lo + 64'd65536) >> 17);
    if (q > lim) begin
      ov = 1'b1;
      q  = lim;
    end
    return neg ? 32'(-longint'(q)) : q[31:0];
  endfunction

  // Apply one accepted item to the shadow state and queue its estimate.
  task automatic predict_item(input tpi_in_t it);
    bit ov;
    int deg;
    int n;
    longint a, b, total;
    logic signed [31:0] h, x;
    tpi_out_t res;
    if (it.operation == OP_LOAD) begin
      // Indices beyond the top degree are dropped silently.
      if (it.coef_index <= TOP_DEGREE) coef_shadow[it.coef_index] = it.coef_value;
      return;
    end
    ov  = 1'b0;
    deg = (degree_shadow > TOP_DEGREE) ? TOP_DEGREE : degree_shadow;
    n   = it.divisions;
    if (n == 0) n = 1;
    if (n > TOP_DIVS) n = TOP_DIVS;
    a = it.lower_end;
    b = it.upper_end;
    h = clip32((b - a) / longint'(n), ov);
    total = longint'(horner_at(it.lower_end, deg, ov)) +
            longint'(horner_at(it.upper_end, deg, ov));
    for (int i = 1; i < n; i++) begin
      x = clip32(a + longint'(i) * longint'(h), ov);
      total += 2 * longint'(horner_at(x, deg, ov));
    end
    res.integral   = scale_sum(total, h, ov);
    res.step_width = h;
    res.overflow   = ov;
    estimate_q.push_back(res);
  endtask

  // Offer one item; gaps are inserted ahead of it at the sender idle rate.
  task automatic send_item(input tpi_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    items_sent++;
    if (it.operation == OP_LOAD) loads_sent++;
  endtask

  // Stop offering and wait until every owed estimate has come back.
  task automatic drain_all();
    @(negedge clk);
    in_valid = 1'b0;
    while (estimate_q.size() != 0) @(posedge clk);
    // A trailing load leaves no result, so the bench waits on past the empty queue.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_degree(input logic [3:0] value);
    drain_all();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    degree_shadow = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic tpi_in_t load_item(input logic [3:0] idx,
                                        input logic signed [31:0] val);
    tpi_in_t it;
    it.operation  = OP_LOAD;
    it.coef_index = idx;
    it.coef_value = val;
    it.lower_end  = $urandom;
    it.upper_end  = $urandom;
    it.divisions  = 16'($urandom);
    return it;
  endfunction

  function automatic tpi_in_t integrate_item(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi,
                                             input logic [15:0] n);
    tpi_in_t it;
    it.operation  = OP_INTEGRATE;
    it.coef_index = 4'($urandom);
    it.coef_value = $urandom;
    it.lower_end  = lo;
    it.upper_end  = hi;
    it.divisions  = n;
    return it;
  endfunction

  // Edge values and the named special cases, nineteen items.
  task automatic test_directed();
    write_degree(4'd0);
    send_item(integrate_item(32'sh0000_0000, 32'sh0001_0000, 16'd1));
    send_item(load_item(4'd0, 32'sh0002_0000));
    send_item(integrate_item(32'sh0000_0000, 32'sh0004_0000, 16'd4));
    // Zero divisions behaves as a single division.
    send_item(integrate_item(32'sh0000_0000, 32'sh0003_0000, 16'd0));
    write_degree(4'd2);
    send_item(load_item(4'd1, 32'shFFFF_0000));
    send_item(load_item(4'd2, 32'sh0000_8000));
    send_item(integrate_item(32'shFFFE_0000, 32'sh0002_0000, 16'd8));
    send_item(integrate_item(32'sh0002_0000, 32'shFFFE_0000, 16'd3));
    // Widest interval; h itself clips for one division.
    send_item(integrate_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd1));
    send_item(integrate_item(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1));
    // Indices past the top degree must not touch the store.
    send_item(load_item(4'd11, 32'sh7FFF_FFFF));
    send_item(load_item(4'd15, 32'sh8000_0000));
    send_item(integrate_item(32'sh0000_0000, 32'sh0001_0000, 16'd2));
    // Extreme coefficients drive the Horner steps into saturation.
    send_item(load_item(4'd10, 32'sh7FFF_FFFF));
    send_item(load_item(4'd9, 32'sh8000_0000));
    write_degree(4'd10);
    send_item(integrate_item(32'sh0010_0000, 32'sh0020_0000, 16'd2));
    send_item(integrate_item(32'shFFF0_0000, 32'sh0000_0000, 16'd1));
    // A degree register above the top degree acts as the top degree.
    write_degree(4'd15);
    send_item(integrate_item(32'sh0000_8000, 32'sh0001_8000, 16'd3));
    write_degree(4'd11);
    send_item(integrate_item(32'sh0000_0000, 32'sh0000_0000, 16'd5));
    drain_all();
  endtask

  // Three long runs of the point loop; the two longest are kept to degree 0 to bound the time.
  task automatic test_many_divisions();
    write_degree(4'd0);
    send_item(load_item(4'd0, 32'sh0001_8000));
    send_item(integrate_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF));
    send_item(integrate_item(32'sh0000_0000, 32'sh0100_0000, 16'd40000));
    write_degree(4'd10);
    send_item(integrate_item(32'shFFFF_0000, 32'sh0001_0000, 16'd1000));
    drain_all();
  endtask

  // Hold the result side for a long stretch so the input backs up.
  task automatic test_output_hold();
    write_degree(4'd3);
    hold_reqs++;
    for (int i = 0; i < 6; i++)
      send_item(integrate_item($urandom, $urandom, 16'($urandom_range(1, 3))));
    drain_all();
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 32'h0000_FFFF))) - 32'sh0000_8000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_point();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
  endfunction

  function automatic logic [15:0] rand_divs();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom_range(1, 4));
    if (pick < 95) return 16'($urandom_range(5, 20));
    if (pick < 98) return 16'd0;
    return 16'($urandom_range(21, 64));
  endfunction

  // Random mix of coefficient loads and integrations, mostly integrations, with the
  // degree moved between bursts.
  task automatic test_random(input int sidle, input int ridle, input int count);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) write_degree(4'($urandom_range(0, 15)));
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) == 0)
          send_item(load_item(4'($urandom_range(11, 15)), $urandom));
        else
          send_item(load_item(4'($urandom_range(0, TOP_DEGREE)), rand_coef()));
      end else begin
        send_item(integrate_item(rand_point(), rand_point(), rand_divs()));
      end
    end
    drain_all();
  endtask

  // Result side: random stall, or a long counted hold when asked for.
  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      hold_ticks = LONG_HOLD;
      holds_done = hold_reqs;
    end
    if (hold_ticks > 0) begin
      hold_ticks--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest owed estimate.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      estimates_seen++;
      if (estimate_q.size() == 0) begin
        $error("unexpected result: integral %h step_width %h",
               out_data.integral, out_data.step_width);
        fail_count++;
      end else begin
        tpi_out_t want;
        want = estimate_q.pop_front();
        if (out_data.integral !== want.integral) begin
          $error("integral: expected %h, got %h", want.integral, out_data.integral);
          fail_count++;
        end
        if (out_data.step_width !== want.step_width) begin
          $error("step_width: expected %h, got %h", want.step_width,
                 out_data.step_width);
          fail_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_data.overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no handshake completes.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_ticks = 0;
    end else begin
      quiet_ticks++;
      if (quiet_ticks >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results owed", estimate_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    hold_reqs      = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    items_sent     = 0;
    loads_sent     = 0;
    degree_shadow  = '0;
    for (int i = 0; i <= TOP_DEGREE; i++) coef_shadow[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_many_divisions();
    test_output_hold();
    test_random(16, 54, 630);
    test_random(54, 16, 630);
    test_random(0, 0, 630);

    while (estimate_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("Sent %0d items (%0d loads), checked %0d estimates across degrees 0-15,",
             items_sent, loads_sent, estimates_seen);
    $display("saturating cases, long division runs and a long output hold.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tpi_pkg.sv
rtl/core/tpi_ram.sv
rtl/core/tpi_div.sv
rtl/core/trapezoid_polynomial_integrator.sv
bench/tb_trapezoid_polynomial_integrator.sv
